// ===== rtl/mhpq_pkg.sv =====
package mhpq_pkg;

   localparam int KeyW  = 32;
   localparam int StatW = 2;
   localparam int CntW  = 7;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [StatW-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_LOAD,
      ST_DN_RD,
      ST_DN_CMP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                   cmd;
      logic signed [KeyW-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [KeyW-1:0] max_value;
      logic [StatW-1:0]       status;
      logic [CntW-1:0]        count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       accept;
      logic       start_ins;
      logic       rd_root;
      logic       load_root;
      logic       move_up;
      logic       dn_rd;
      logic       move_dn;
      logic       wr_hold;
      logic       resp_load;
      status_type resp_code;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic last_one;
      logic at_root;
      logic up_swap;
      logic dn_stop;
      logic rsp_busy;
   } flag_type;

endpackage

// ===== rtl/mhpq_ctrl.sv =====
module mhpq_ctrl
   import mhpq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_cmd,
   input  flag_type flags,
   output logic     req_stall,
   output ctl_type  ctl
);

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         code_ff  <= STAT_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               code_in = STAT_OK;
               if (req_cmd == OP_REMOVE) begin
                  if (flags.empty) begin
                     code_in  = STAT_EMPTY;
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_LOAD;
                  end
               end else begin
                  if (flags.full) begin
                     code_in  = STAT_FULL;
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_UP_CHK;
                  end
               end
            end
         end
         ST_UP_CHK: begin
            state_in = flags.at_root ? ST_RESP : ST_UP_CMP;
         end
         ST_UP_CMP: begin
            state_in = flags.up_swap ? ST_UP_CHK : ST_RESP;
         end
         ST_LOAD: begin
            state_in = flags.last_one ? ST_RESP : ST_DN_RD;
         end
         ST_DN_RD: begin
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            state_in = flags.dn_stop ? ST_RESP : ST_DN_RD;
         end
         ST_RESP: begin
            if (!flags.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      ctl           = '0;
      ctl.resp_code = code_ff;
      req_stall     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.accept = 1'b1;
               if (req_cmd == OP_REMOVE) begin
                  ctl.rd_root = !flags.empty;
               end else begin
                  ctl.start_ins = !flags.full;
               end
            end
         end
         ST_UP_CHK: begin
            if (flags.at_root) begin
               ctl.wr_hold = 1'b1;
            end
         end
         ST_UP_CMP: begin
            if (flags.up_swap) begin
               ctl.move_up = 1'b1;
            end else begin
               ctl.wr_hold = 1'b1;
            end
         end
         ST_LOAD: begin
            ctl.load_root = 1'b1;
         end
         ST_DN_RD: begin
            ctl.dn_rd = 1'b1;
         end
         ST_DN_CMP: begin
            if (flags.dn_stop) begin
               ctl.wr_hold = 1'b1;
            end else begin
               ctl.move_dn = 1'b1;
            end
         end
         ST_RESP: begin
            ctl.resp_load = !flags.rsp_busy;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

endmodule

// ===== rtl/mhpq_dpath.sv =====
module mhpq_dpath
   import mhpq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctl_type                ctl,
   input  logic signed [KeyW-1:0] req_value,
   output flag_type               flags,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output rsp_type                rsp_data
);

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NumW = $clog2(DEPTH + 1);
   localparam int ChW  = IdxW + 2;

   logic signed [KeyW-1:0] mem [DEPTH];

   logic [NumW-1:0]        count_ff, count_in;
   logic [IdxW-1:0]        pos_ff, pos_in;
   logic signed [KeyW-1:0] hold_ff, hold_in;
   logic signed [KeyW-1:0] maxv_ff, maxv_in;
   logic signed [KeyW-1:0] rd_a_ff, rd_b_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [IdxW-1:0]        rd_addr_a, rd_addr_b, parent_idx, last_idx;
   logic                   wr_en;
   logic signed [KeyW-1:0] wr_data;

   logic [ChW-1:0]         left_idx, right_idx;
   logic                   left_ok, right_ok, take_l, take_r;
   logic signed [KeyW-1:0] big_v, child_v;
   logic [IdxW-1:0]        child_idx;

   assign parent_idx = (pos_ff - IdxW'(1)) >> 1;
   assign last_idx   = IdxW'(count_ff - NumW'(1));
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + ChW'(1);
   assign left_ok    = left_idx < ChW'(count_ff);
   assign right_ok   = right_idx < ChW'(count_ff);

   // larger child, left wins a tie, parent stays on a tie
   assign take_l    = left_ok && (hold_ff < rd_a_ff);
   assign big_v     = take_l ? rd_a_ff : hold_ff;
   assign take_r    = right_ok && (big_v < rd_b_ff);
   assign child_v   = take_r ? rd_b_ff : rd_a_ff;
   assign child_idx = take_r ? right_idx[IdxW-1:0] : left_idx[IdxW-1:0];

   always_comb begin
      rd_addr_a = parent_idx;
      rd_addr_b = last_idx;
      if (ctl.rd_root) begin
         rd_addr_a = '0;
      end else if (ctl.dn_rd) begin
         rd_addr_a = left_idx[IdxW-1:0];
         rd_addr_b = right_idx[IdxW-1:0];
      end
   end

   assign wr_en   = ctl.wr_hold | ctl.move_up | ctl.move_dn;
   assign wr_data = ctl.move_up ? rd_a_ff : (ctl.move_dn ? child_v : hold_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pos_ff] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      hold_in  = hold_ff;
      maxv_in  = maxv_ff;
      if (ctl.accept) begin
         maxv_in = '0;
      end
      if (ctl.start_ins) begin
         count_in = count_ff + NumW'(1);
         pos_in   = IdxW'(count_ff);
         hold_in  = req_value;
      end
      if (ctl.load_root) begin
         count_in = count_ff - NumW'(1);
         pos_in   = '0;
         hold_in  = rd_b_ff;
         maxv_in  = rd_a_ff;
      end
      if (ctl.move_up) begin
         pos_in = parent_idx;
      end
      if (ctl.move_dn) begin
         pos_in = child_idx;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (ctl.resp_load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.max_value = maxv_ff;
         rsp_data_in.status    = ctl.resp_code;
         rsp_data_in.count     = CntW'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      hold_ff     <= hold_in;
      maxv_ff     <= maxv_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign flags.full     = (count_ff == NumW'(DEPTH));
   assign flags.empty    = (count_ff == '0);
   assign flags.last_one = (count_ff == NumW'(1));
   assign flags.at_root  = (pos_ff == '0);
   assign flags.up_swap  = (rd_a_ff < hold_ff);
   assign flags.dn_stop  = !take_l && !take_r;
   assign flags.rsp_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/max_heap_priority_queue_unit.sv =====
// channel   direction  word                          handshake
// req       in         req_type  {cmd, value}        req_valid / req_stall
// rsp       out        rsp_type  {max_value, status, count}  rsp_valid / rsp_stall
//
// one word at a time: req_stall holds off the next word until the result is loaded
// into the output register; insert climbs from the new last slot while the parent
// is smaller; remove moves the last entry to the root and sinks it below larger
// children; full insert or empty remove goes straight to the response
// reset clears the entry count and the handshake state; heap memory is not cleared
// req_stall stays high while a word is in work; a result waits in the output register
module max_heap_priority_queue_unit
   import mhpq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_type  ctl;
   flag_type flags;

   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .flags     (flags),
      .req_stall (req_stall),
      .ctl       (ctl)
   );

   mhpq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_value (req_data.value),
      .flags     (flags),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
